// ===== design/rau_pkg.sv =====
`timescale 1ns / 1ps
package rau_pkg;
  localparam int WordBitsDef = 32;
  localparam int MagBits = 64;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd1,
    FN_MUL = 3'd2,
    FN_DIV = 3'd3,
    FN_CMP = 3'd4,
    FN_NEG = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  // classified job passed from front to back
  typedef struct packed {
    logic                direct;   // result already known, no reduction
    logic                neg;
    logic [MagBits-1:0]  mag;
    logic [MagBits-1:0]  den;
    logic                lt;
    logic                eq;
    logic                gt;
    logic [1:0]          st;
    logic                zero_den; // den field of direct result is zero
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_GCD,
    BK_DIVM,
    BK_DIVD,
    BK_DONE
  } bk_state_t;
endpackage

// ===== design/rau_if.sv =====
`timescale 1ns / 1ps
interface rau_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] a_num;
  logic [30:0] a_den;
  logic [31:0] b_num;
  logic [30:0] b_den;
  modport source(output valid, func, a_num, a_den, b_num, b_den, input ready);
  modport sink(input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic        is_less;
  logic        is_equal;
  logic        is_greater;
  logic [1:0]  status;
  modport source(output valid, res_num, res_den, is_less, is_equal, is_greater, status,
                 input ready);
  modport sink(input valid, res_num, res_den, is_less, is_equal, is_greater, status,
               output ready);
endinterface

// ===== design/rational_arith_unit.sv =====
`timescale 1ns / 1ps
// Compare, error and zero results are known up front and skip the divider; all other
// results are reduced by the 1-bit-per-cycle divider
// shared by the GCD remainders and the two reductions.
// The back end takes one item at a time; the front holds two more.
// Reset: synchronous active-high rst clears all valid and state flags.
module rational_arith_unit #(
  parameter int WORD_BITS = rau_pkg::WordBitsDef
) (
  input  logic      clk,
  input  logic      rst,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;

  logic job_valid, job_ready;
  job_t job;

  rau_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  rau_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk(clk), .rst(rst),
    .job_valid(job_valid), .job_ready(job_ready), .job(job), .out_ch(out_ch)
  );
endmodule

// ===== design/rau_front.sv =====
`timescale 1ns / 1ps
module rau_front (
  input  logic            clk,
  input  logic            rst,
  rau_in_if.sink          in_ch,
  output logic            job_valid,
  input  logic            job_ready,
  output rau_pkg::job_t   job
);
  import rau_pkg::*;

  // stage 1: products; stage 2: classify
  logic               s1_valid;
  logic [2:0]         s1_func;
  logic               s1_bad;
  logic signed [63:0] p_ab, p_ba, p_nn, p_dd;
  logic               s1_bnz;
  logic signed [63:0] s1_an, s1_ad;
  logic               s2_free;
  job_t               j_next;
  logic signed [64:0] num, den, l_sum;

  assign s2_free = !job_valid || job_ready;
  assign in_ch.ready = !s1_valid || s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1_func <= in_ch.func;
      s1_bad  <= (in_ch.a_den == '0) || (in_ch.func != FN_NEG && in_ch.b_den == '0);
      s1_bnz  <= in_ch.b_num != '0;
      p_ab <= $signed(in_ch.a_num) * $signed({1'b0, in_ch.b_den});
      p_ba <= $signed(in_ch.b_num) * $signed({1'b0, in_ch.a_den});
      p_nn <= $signed(in_ch.a_num) * $signed(in_ch.b_num);
      p_dd <= $signed({1'b0, in_ch.a_den}) * $signed({1'b0, in_ch.b_den});
      s1_an <= 64'(signed'(in_ch.a_num));
      s1_ad <= 64'({1'b0, in_ch.a_den});
    end
  end

  always_comb begin
    j_next = '0;
    num = '0;
    den = 65'sd1;
    l_sum = {p_ab[63], p_ab} - {p_ba[63], p_ba};
    unique case (s1_func)
      FN_ADD: begin num = {p_ab[63], p_ab} + {p_ba[63], p_ba}; den = {1'b0, p_dd}; end
      FN_SUB: begin num = l_sum; den = {1'b0, p_dd}; end
      FN_MUL: begin num = {p_nn[63], p_nn}; den = {1'b0, p_dd}; end
      FN_DIV: begin num = {p_ab[63], p_ab}; den = {p_ba[63], p_ba}; end
      FN_NEG: begin num = -{s1_an[63], s1_an}; den = {1'b0, s1_ad}; end
      default: ;
    endcase
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    j_next.neg = num[64];
    j_next.mag = num[64] ? 64'(-num) : num[63:0];
    j_next.den = den[63:0];
    if (s1_func > FN_NEG) begin
      j_next.direct = 1'b1;
      j_next.zero_den = 1'b1;
      j_next.neg = 1'b0;
    end else if (s1_bad || (s1_func == FN_DIV && !s1_bnz)) begin
      j_next.direct = 1'b1;
      j_next.zero_den = 1'b1;
      j_next.neg = 1'b0;
      j_next.st = ST_DIVZ;
    end else if (s1_func == FN_CMP) begin
      j_next.direct = 1'b1;
      j_next.zero_den = 1'b1;
      j_next.neg = 1'b0;
      j_next.lt = l_sum < 0;
      j_next.eq = l_sum == 0;
      j_next.gt = l_sum > 0;
    end else if (j_next.mag == '0) begin
      j_next.direct = 1'b1;
      j_next.neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (s2_free) begin
      job_valid <= s1_valid;
    end
    if (s2_free && s1_valid) begin
      job <= j_next;
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid && $stable(job))
    else $error("job changed while stalled");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> $countones({job.lt, job.eq, job.gt}) <= 1)
    else $error("compare flags not exclusive");
  a_direct: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job.direct |-> job.mag != '0 && job.den != '0)
    else $error("reduction job with zero operand");
`endif
endmodule

// ===== design/rau_back.sv =====
`timescale 1ns / 1ps
module rau_back #(
  parameter int WORD_BITS = rau_pkg::WordBitsDef
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  rau_pkg::job_t  job,
  rau_out_if.source      out_ch
);
  import rau_pkg::*;

  localparam logic [MagBits:0] Lim = (MagBits+1)'(1) << (WORD_BITS - 1);

  bk_state_t state, state_next;
  job_t cur;
  logic [MagBits-1:0] gx, gy;         // Euclid operands
  logic [MagBits-1:0] rem, quo, dvs;  // restoring divider
  logic [6:0]          cnt;
  logic [MagBits-1:0] q_mag;
  logic [MagBits:0]    trial;
  logic                over;

  assign job_ready = state == BK_IDLE;
  assign trial = {rem, quo[MagBits-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (job_valid) state_next = job.direct ? BK_DONE : BK_GCD;
      BK_GCD:  if (gy == '0 && cnt == '0) state_next = BK_DIVM;
      BK_DIVM: if (cnt == 7'd63) state_next = BK_DIVD;
      BK_DIVD: if (cnt == 7'd63) state_next = BK_DONE;
      BK_DONE: if (out_ch.ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // GCD x % y and both reductions use the divider; cnt counts 64 steps
  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: if (job_valid) begin
        cur <= job;
        gx <= job.mag;
        gy <= job.den;
        rem <= '0;
        quo <= job.mag;
        dvs <= job.den;
        cnt <= '0;
      end
      BK_GCD: begin
        if (gy != '0 || cnt != '0) begin
          if (trial[MagBits]) begin
            rem <= {rem[MagBits-2:0], quo[MagBits-1]};
            quo <= {quo[MagBits-2:0], 1'b0};
          end else begin
            rem <= trial[MagBits-1:0];
            quo <= {quo[MagBits-2:0], 1'b1};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) begin
            cnt <= '0;
            gx <= gy;
            gy <= trial[MagBits] ? {rem[MagBits-2:0], quo[MagBits-1]} : trial[MagBits-1:0];
            rem <= '0;
            quo <= gy;
            dvs <= trial[MagBits] ? {rem[MagBits-2:0], quo[MagBits-1]} : trial[MagBits-1:0];
          end
        end else begin
          rem <= '0;
          quo <= cur.mag;
          dvs <= gx;
          cnt <= '0;
        end
      end
      BK_DIVM, BK_DIVD: begin
        if (trial[MagBits]) begin
          rem <= {rem[MagBits-2:0], quo[MagBits-1]};
          quo <= {quo[MagBits-2:0], 1'b0};
        end else begin
          rem <= trial[MagBits-1:0];
          quo <= {quo[MagBits-2:0], 1'b1};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          cnt <= '0;
          rem <= '0;
          if (state == BK_DIVM) begin
            q_mag <= {quo[MagBits-2:0], !trial[MagBits]};
            quo <= cur.den;
          end else begin
            cur.den <= {quo[MagBits-2:0], !trial[MagBits]};
            cur.mag <= q_mag;
          end
        end
      end
      default: ;
    endcase
  end

  assign over = !cur.direct &&
    (({1'b0, cur.den} > Lim - 1) || (cur.neg ? {1'b0, cur.mag} > Lim : {1'b0, cur.mag} > Lim - 1));

  always_comb begin
    out_ch.valid = state == BK_DONE;
    out_ch.is_less = cur.lt;
    out_ch.is_equal = cur.eq;
    out_ch.is_greater = cur.gt;
    out_ch.status = cur.st;
    if (cur.direct) begin
      out_ch.res_num = '0;
      out_ch.res_den = cur.zero_den ? '0 : 31'd1;
    end else if (over) begin
      out_ch.res_num = '0;
      out_ch.res_den = '0;
      out_ch.status = ST_OVF;
    end else begin
      out_ch.res_num = cur.neg ? 32'(-cur.mag) : cur.mag[31:0];
      out_ch.res_den = cur.den[30:0];
    end
  end

`ifndef SYNTHESIS
  a_take: assert property (@(posedge clk) disable iff (rst)
    state == BK_IDLE && job_valid |=> state == BK_DONE || state == BK_GCD)
    else $error("job not taken");
  a_gcd_nz: assert property (@(posedge clk) disable iff (rst)
    state == BK_DIVM |-> dvs != '0)
    else $error("zero gcd");
  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status == ST_OK && !cur.direct |-> out_ch.res_den != '0)
    else $error("zero denominator on success");
`endif
endmodule
